// ----- src/separable_conv_stream_core_assert.svh -----
// Assertion macros shared by the separable convolution core.
`ifndef SEPARABLE_CONV_STREAM_CORE_ASSERT_SVH
`define SEPARABLE_CONV_STREAM_CORE_ASSERT_SVH
`ifndef SYNTH
`define SCS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scs assertion failed");
`define SCS_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("scs forbidden condition");
`else
`define SCS_ASSERT(lbl, clk, rst_n, prop)
`define SCS_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- src/scs_pkg.sv -----
// Shared types and constants of the separable convolution core.
package scs_pkg;

    localparam int IDX_W     = 4;
    localparam int ACC_W     = 44;
    localparam int PROD_W    = 40;
    localparam int HVAL_W    = 24;
    localparam int VAL_W     = 26;
    localparam int COEF_W    = 16;
    localparam int COEF_VEC_W = 192;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_WIDE = 2'd1;
    localparam logic [1:0] MODE_DIFF = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HCOEF0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HCOEF1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HCOEF2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VCOEF0 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VCOEF1 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VCOEF2 = 3'd7;

    localparam logic signed [ACC_W-1:0] H_MAX_A = 44'sd8388607;
    localparam logic signed [ACC_W-1:0] H_MIN_A = -44'sd8388608;
    localparam logic signed [ACC_W-1:0] V_MAX_A = 44'sd33554431;
    localparam logic signed [ACC_W-1:0] V_MIN_A = -44'sd33554432;
    localparam logic signed [ACC_W-1:0] BYTE_MAX_A = 44'sd255;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HMAC,
        ST_HWAIT,
        ST_HLATCH,
        ST_VREAD,
        ST_VLAST,
        ST_VHWR,
        ST_VWAIT,
        ST_VDONE
    } t_state;

    typedef struct packed {
        logic             take;
        logic             mul_h;
        logic             mul_v;
        logic             mul_hv;
        logic             h_latch;
        logic             wsel_h;
        logic             out_load;
        logic             row_last;
        logic             frame_last;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] n;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ----- src/scs_ram.sv -----
// Generic simple dual-port RAM with registered read.
module scs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 10240
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/scs_dp.sv -----
// Datapath: tap window, shared multiply-accumulate, floor scaling with clamp and output word.
module scs_dp #(
    parameter int MAX_RADIUS = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  scs_pkg::t_cmd                       i_cmd,
    input  logic [1:0]                          i_mode,
    input  logic [7:0]                          i_pixel,
    input  logic [7:0]                          i_pixel_sub,
    input  logic [scs_pkg::COEF_VEC_W-1:0]      i_hcoef,
    input  logic [scs_pkg::COEF_VEC_W-1:0]      i_vcoef,
    input  logic signed [scs_pkg::HVAL_W-1:0]   i_rdata,
    output logic signed [scs_pkg::HVAL_W-1:0]   o_wdata,
    output scs_pkg::t_sts                       o_sts,
    output logic                                o_m_valid,
    input  logic                                i_m_ready,
    output logic signed [scs_pkg::VAL_W-1:0]    o_value,
    output logic                                o_row_last,
    output logic                                o_frame_last
);

    localparam int NTAPS  = 2 * MAX_RADIUS + 1;
    localparam int TAP_IW = $clog2(NTAPS);
    localparam int IDX_W_L = scs_pkg::IDX_W;

    logic signed [8:0]                     r_tap [NTAPS];
    logic signed [scs_pkg::PROD_W-1:0]     r_prod;
    logic                                  r_pv;
    logic signed [scs_pkg::ACC_W-1:0]      r_acc;
    logic signed [scs_pkg::HVAL_W-1:0]     r_h;
    logic                                  r_ovld;
    logic signed [scs_pkg::VAL_W-1:0]      r_value;
    logic                                  r_row_last;
    logic                                  r_frame_last;

    logic signed [8:0]                     px;
    logic [IDX_W_L-1:0]                    tap_sel;
    logic signed [scs_pkg::COEF_W-1:0]     op_a;
    logic signed [scs_pkg::HVAL_W-1:0]     op_b;
    logic signed [scs_pkg::HVAL_W-1:0]     h_val;
    logic signed [scs_pkg::VAL_W-1:0]      v_val;
    logic                                  m0;

    assign m0 = (i_mode == scs_pkg::MODE_BYTE);

    always_comb begin
        if (i_mode == scs_pkg::MODE_DIFF) begin
            px = $signed({1'b0, i_pixel}) - $signed({1'b0, i_pixel_sub});
        end else begin
            px = $signed({1'b0, i_pixel});
        end
    end

    // Operand select for the one shared multiplier
    always_comb begin
        tap_sel = i_cmd.n - i_cmd.idx;
        if (i_cmd.mul_h) begin
            op_a = $signed(i_hcoef[{i_cmd.idx, 4'b0000} +: scs_pkg::COEF_W]);
            op_b = scs_pkg::HVAL_W'(r_tap[tap_sel[TAP_IW-1:0]]);
        end else if (i_cmd.mul_v) begin
            op_a = $signed(i_vcoef[{i_cmd.idx, 4'b0000} +: scs_pkg::COEF_W]);
            op_b = i_rdata;
        end else begin
            op_a = $signed(i_vcoef[{i_cmd.idx, 4'b0000} +: scs_pkg::COEF_W]);
            op_b = r_h;
        end
    end

    // Horizontal result: byte clamp or floor(H/64) clamped to 24 bits
    always_comb begin
        logic signed [scs_pkg::ACC_W-1:0] q;
        q = r_acc >>> 14;
        if (m0) begin
            if (r_acc < 0) begin
                h_val = '0;
            end else if (q > scs_pkg::BYTE_MAX_A) begin
                h_val = scs_pkg::HVAL_W'(255);
            end else begin
                h_val = scs_pkg::HVAL_W'(q);
            end
        end else begin
            q = r_acc >>> 6;
            if (q > scs_pkg::H_MAX_A) begin
                h_val = scs_pkg::HVAL_W'(scs_pkg::H_MAX_A);
            end else if (q < scs_pkg::H_MIN_A) begin
                h_val = scs_pkg::HVAL_W'(scs_pkg::H_MIN_A);
            end else begin
                h_val = scs_pkg::HVAL_W'(q);
            end
        end
    end

    // Vertical result
    always_comb begin
        logic signed [scs_pkg::ACC_W-1:0] q;
        q = r_acc >>> 14;
        if (m0) begin
            if (r_acc < 0) begin
                v_val = '0;
            end else if (q > scs_pkg::BYTE_MAX_A) begin
                v_val = scs_pkg::VAL_W'(255);
            end else begin
                v_val = scs_pkg::VAL_W'(q);
            end
        end else if (q > scs_pkg::V_MAX_A) begin
            v_val = scs_pkg::VAL_W'(scs_pkg::V_MAX_A);
        end else if (q < scs_pkg::V_MIN_A) begin
            v_val = scs_pkg::VAL_W'(scs_pkg::V_MIN_A);
        end else begin
            v_val = scs_pkg::VAL_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_tap[0] <= px;
            for (int k = 1; k < NTAPS; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
        r_prod <= op_a * op_b;
        if (i_cmd.h_latch) begin
            r_h <= h_val;
        end
        if (i_cmd.out_load) begin
            r_value      <= v_val;
            r_row_last   <= i_cmd.row_last;
            r_frame_last <= i_cmd.frame_last;
        end
        if (!i_rst_n) begin
            for (int k = 0; k < NTAPS; k++) begin
                r_tap[k] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_acc  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_h | i_cmd.mul_v | i_cmd.mul_hv;
            if (i_cmd.take || i_cmd.h_latch) begin
                r_acc <= '0;
            end else if (r_pv) begin
                r_acc <= r_acc + scs_pkg::ACC_W'(r_prod);
            end
            if (i_cmd.out_load) begin
                r_ovld <= 1'b1;
            end else if (i_m_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_wdata         = i_cmd.wsel_h ? r_h : i_rdata;
    assign o_sts.out_free  = !r_ovld || i_m_ready;
    assign o_m_valid       = r_ovld;
    assign o_value         = r_value;
    assign o_row_last      = r_row_last;
    assign o_frame_last    = r_frame_last;

endmodule

// ----- src/scs_ctrl.sv -----
// Controller: raster counters, tap sequencing and line store addressing.
`include "separable_conv_stream_core_assert.svh"
module scs_ctrl #(
    parameter int LINE_WIDTH = 1024,
    parameter int MAX_RADIUS = 5
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s_valid,
    output logic                                          o_s_ready,
    input  logic                                          i_line_end,
    input  logic                                          i_frame_end,
    input  logic [2:0]                                    i_radius,
    input  scs_pkg::t_sts                                 i_sts,
    output scs_pkg::t_cmd                                 o_cmd,
    output logic                                          o_ram_we,
    output logic [$clog2(LINE_WIDTH*2*MAX_RADIUS)-1:0]    o_ram_waddr,
    output logic [$clog2(LINE_WIDTH*2*MAX_RADIUS)-1:0]    o_ram_raddr
);

    localparam int HIST = 2 * MAX_RADIUS;
    localparam int CW   = $clog2(LINE_WIDTH + 1);
    localparam int RW   = $clog2(HIST + 1);
    localparam int AW   = $clog2(LINE_WIDTH * HIST);
    localparam int IW   = scs_pkg::IDX_W;

    scs_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [AW-1:0]   r_base;
    logic            r_do_out;
    logic            r_le;
    logic            r_fe;
    logic            r_rd_pend;
    logic [IW-1:0]   r_rd_j;

    logic [2:0]      rad;
    logic [IW-1:0]   n;
    logic            accept;
    logic            do_col;
    logic            reading;

    assign rad    = (i_radius > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : i_radius;
    assign n      = {rad, 1'b0};
    assign accept = i_s_valid && o_s_ready;
    assign do_col = (r_col >= CW'(n)) && (r_col < CW'(LINE_WIDTH));
    assign reading = (r_state == scs_pkg::ST_VREAD);

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            scs_pkg::ST_IDLE: begin
                if (accept && do_col) begin
                    n_state = scs_pkg::ST_HMAC;
                    n_cnt   = '0;
                end
            end
            scs_pkg::ST_HMAC: begin
                if (r_cnt == n) begin
                    n_state = scs_pkg::ST_HWAIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            scs_pkg::ST_HWAIT: n_state = scs_pkg::ST_HLATCH;
            scs_pkg::ST_HLATCH: begin
                n_state = scs_pkg::ST_VREAD;
                n_cnt   = IW'(HIST - 1);
            end
            scs_pkg::ST_VREAD: begin
                if (r_cnt == '0) begin
                    n_state = scs_pkg::ST_VLAST;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            scs_pkg::ST_VLAST: n_state = scs_pkg::ST_VHWR;
            scs_pkg::ST_VHWR:  n_state = scs_pkg::ST_VWAIT;
            scs_pkg::ST_VWAIT: n_state = scs_pkg::ST_VDONE;
            scs_pkg::ST_VDONE: begin
                if (!r_do_out || i_sts.out_free) begin
                    n_state = scs_pkg::ST_IDLE;
                end
            end
            default: n_state = scs_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_ready        = (r_state == scs_pkg::ST_IDLE);
        o_cmd            = '0;
        o_cmd.n          = n;
        o_cmd.take       = accept;
        o_cmd.row_last   = r_le || r_fe;
        o_cmd.frame_last = r_fe;
        o_ram_we         = 1'b0;
        o_ram_waddr      = r_base + AW'(r_rd_j) + AW'(1);
        o_ram_raddr      = r_base + AW'(r_cnt);
        // column shift: word read at j is written to j+1 in the next cycle;
        // the oldest slot is read but not written back, so it drops out
        if (r_rd_pend) begin
            o_ram_we = (r_rd_j != IW'(HIST - 1));
            if (r_rd_j < n) begin
                o_cmd.mul_v = 1'b1;
                o_cmd.idx   = IW'(n - r_rd_j - 1'b1);
            end
        end
        case (r_state)
            scs_pkg::ST_HMAC: begin
                o_cmd.mul_h = 1'b1;
                o_cmd.idx   = r_cnt;
            end
            scs_pkg::ST_HLATCH: o_cmd.h_latch = 1'b1;
            scs_pkg::ST_VHWR: begin
                o_ram_we     = 1'b1;
                o_ram_waddr  = r_base;
                o_cmd.wsel_h = 1'b1;
                o_cmd.mul_hv = 1'b1;
                o_cmd.idx    = n;
            end
            scs_pkg::ST_VDONE: o_cmd.out_load = r_do_out && i_sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= scs_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_rd_pend <= 1'b0;
            r_do_out  <= 1'b0;
            r_le      <= 1'b0;
            r_fe      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_pend <= reading;
            if (accept) begin
                r_do_out <= (IW'(r_row) >= n);
                r_le     <= i_line_end;
                r_fe     <= i_frame_end;
                if (i_frame_end) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (i_line_end) begin
                    r_col <= '0;
                    if (IW'(r_row) < n) begin
                        r_row <= r_row + 1'b1;
                    end
                end else if (r_col < CW'(LINE_WIDTH)) begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_j <= r_cnt;
        if (accept) begin
            r_base <= AW'(r_col) * AW'(HIST);
        end
    end

    `SCS_NEVER(a_no_addr_clash, i_clk, i_rst_n, o_ram_we && reading && o_ram_waddr == o_ram_raddr)
    `SCS_ASSERT(a_pend_after_read, i_clk, i_rst_n, r_rd_pend |-> $past(r_state) == scs_pkg::ST_VREAD)
    `SCS_ASSERT(a_latch_after_wait, i_clk, i_rst_n, (r_state == scs_pkg::ST_HLATCH) |-> $past(r_state) == scs_pkg::ST_HWAIT)
    `SCS_NEVER(a_no_take_busy, i_clk, i_rst_n, o_cmd.take && (o_cmd.mul_h || o_cmd.mul_v || o_cmd.h_latch))

endmodule

// ----- src/separable_conv_stream_core.sv -----
// An interior-column pixel (n=2R) runs ST_HMAC, ST_HWAIT, ST_HLATCH, ST_VREAD, ST_VLAST,
// ST_VHWR, ST_VWAIT and ST_VDONE; its word is loaded in ST_VDONE if its row is at least n.
// No new pixel is taken before ST_IDLE; border pixels stay in ST_IDLE. A word still
// waiting at the output holds ST_VDONE until taken. The pace is bound by the single shared
// multiplier and the line store column shift. Reset (i_rst_n low, synchronous) clears
// counters, tap window, accumulator and output valid; the line store has no reset.
module separable_conv_stream_core #(
    parameter int LINE_WIDTH = 1024,
    parameter int MAX_RADIUS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [15:0]                   i_s_tdata,  // pixel[7:0], pixel_sub[15:8]
    input  logic                          i_s_tlast,  // line_end
    input  logic                          i_s_tuser,  // frame_end
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,  // value[25:0], zeros above
    output logic                          o_m_tlast,  // row_last
    output logic                          o_m_tuser,  // frame_last
    input  logic                          i_cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scs_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH = LINE_WIDTH * 2 * MAX_RADIUS;
    localparam int AW    = $clog2(DEPTH);

    logic [1:0]                 r_mode;
    logic [2:0]                 r_radius;
    logic [scs_pkg::CFG_W-1:0]  r_hcoef [3];
    logic [scs_pkg::CFG_W-1:0]  r_vcoef [3];

    scs_pkg::t_cmd              cmd;
    scs_pkg::t_sts              sts;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    logic signed [scs_pkg::HVAL_W-1:0] ram_wdata;
    logic signed [scs_pkg::HVAL_W-1:0] ram_rdata;
    logic signed [scs_pkg::VAL_W-1:0]  value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= scs_pkg::MODE_WIDE;
            r_radius <= 3'd1;
            for (int k = 0; k < 3; k++) begin
                r_hcoef[k] <= '0;
                r_vcoef[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                scs_pkg::REG_MODE:   r_mode     <= i_cfg_data[1:0];
                scs_pkg::REG_RADIUS: r_radius   <= i_cfg_data[2:0];
                scs_pkg::REG_HCOEF0: r_hcoef[0] <= i_cfg_data;
                scs_pkg::REG_HCOEF1: r_hcoef[1] <= i_cfg_data;
                scs_pkg::REG_HCOEF2: r_hcoef[2] <= i_cfg_data;
                scs_pkg::REG_VCOEF0: r_vcoef[0] <= i_cfg_data;
                scs_pkg::REG_VCOEF1: r_vcoef[1] <= i_cfg_data;
                scs_pkg::REG_VCOEF2: r_vcoef[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    scs_ctrl #(
        .LINE_WIDTH (LINE_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_tvalid),
        .o_s_ready   (o_s_tready),
        .i_line_end  (i_s_tlast),
        .i_frame_end (i_s_tuser),
        .i_radius    (r_radius),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_raddr (ram_raddr)
    );

    scs_dp #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (r_mode),
        .i_pixel      (i_s_tdata[7:0]),
        .i_pixel_sub  (i_s_tdata[15:8]),
        .i_hcoef      ({r_hcoef[2], r_hcoef[1], r_hcoef[0]}),
        .i_vcoef      ({r_vcoef[2], r_vcoef[1], r_vcoef[0]}),
        .i_rdata      (ram_rdata),
        .o_wdata      (ram_wdata),
        .o_sts        (sts),
        .o_m_valid    (o_m_tvalid),
        .i_m_ready    (i_m_tready),
        .o_value      (value),
        .o_row_last   (o_m_tlast),
        .o_frame_last (o_m_tuser)
    );

    scs_ram #(
        .WIDTH (scs_pkg::HVAL_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_tdata = {6'b0, value};

endmodule
